// ----- src/mqbf_pkg.sv -----
// shared types, codes and defaults for the multi-queue byte fifo
`default_nettype none

package mqbf_pkg;

    localparam int QUEUES_DEFAULT = 4;
    localparam int DEPTH_DEFAULT  = 16;

    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] queue_id;
        logic [7:0] data_in;
    } req_t;

    typedef struct packed {
        logic       failed;
        logic [7:0] data_out;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

`default_nettype wire

// ----- src/mqbf_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module mqbf_ram #(
    parameter int WIDTH = 8,
    parameter int WORDS = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(WORDS)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(WORDS)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [WORDS];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/mqbf_ctrl.sv -----
// sequencer: accept one beat, run it against the queue state, present the result
`default_nettype none

module mqbf_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output      logic          req_stall,
    output      logic          rsp_valid,
    input  wire logic          rsp_stall,
    output      mqbf_pkg::cmd_t cmd
);

    mqbf_pkg::state_t state_reg;
    mqbf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mqbf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mqbf_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = mqbf_pkg::ST_EXEC;
                end
            end
            mqbf_pkg::ST_EXEC:
            begin
                state_next = mqbf_pkg::ST_RESP;
            end
            mqbf_pkg::ST_RESP:
            begin
                if (!rsp_stall)
                begin
                    state_next = mqbf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mqbf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        rsp_valid = 1'b0;
        cmd.load  = 1'b0;
        cmd.exec  = 1'b0;
        unique case (state_reg)
            mqbf_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                cmd.load  = req_valid;
            end
            mqbf_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            mqbf_pkg::ST_RESP:
            begin
                rsp_valid = 1'b1;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/mqbf_dp.sv -----
// datapath: latched request, per-queue pointers, byte store and result flags
`default_nettype none

module mqbf_dp #(
    parameter int QUEUES = mqbf_pkg::QUEUES_DEFAULT,
    parameter int DEPTH  = mqbf_pkg::DEPTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mqbf_pkg::cmd_t cmd,
    input  wire mqbf_pkg::req_t req,
    output      mqbf_pkg::rsp_t rsp
);

    localparam int QW    = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int PW    = $clog2(DEPTH);
    localparam int PW1   = PW + 1;
    localparam int WORDS = QUEUES * DEPTH;
    localparam int AW    = $clog2(WORDS);
    localparam logic [PW:0] DEPTH_W  = PW1'(DEPTH);
    localparam logic [6:0]  QUEUES_W = 7'(QUEUES);

    mqbf_pkg::req_t req_reg;
    logic           failed_reg;
    logic           pop_ok_reg;

    logic [PW-1:0] write_pos_reg [QUEUES];
    logic [PW-1:0] read_pos_reg  [QUEUES];
    logic          wrapped_reg   [QUEUES];

    logic [QW-1:0] qi;
    logic          in_range;
    logic [PW-1:0] wp;
    logic [PW-1:0] rp;
    logic          wr;
    logic          empty;
    logic          full;
    logic          do_push;
    logic          do_pop;
    logic          failed_next;
    logic [PW:0]   wp_inc;
    logic [PW:0]   rp_inc;
    logic [AW-1:0] base;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;

    assign qi       = QW'(req_reg.queue_id);
    assign in_range = {5'd0, req_reg.queue_id} < QUEUES_W;
    assign wp       = write_pos_reg[qi];
    assign rp       = read_pos_reg[qi];
    assign wr       = wrapped_reg[qi];
    assign empty    = !wr && (rp == wp);
    assign full     = wr && (rp == wp);
    assign wp_inc   = {1'b0, wp} + 1'b1;
    assign rp_inc   = {1'b0, rp} + 1'b1;

    always_comb
    begin
        do_push     = 1'b0;
        do_pop      = 1'b0;
        failed_next = 1'b0;
        if (!in_range)
        begin
            failed_next = 1'b1;
        end
        else
        begin
            case (req_reg.func)
                mqbf_pkg::FUNC_PUSH:
                begin
                    failed_next = full;
                    do_push     = cmd.exec && !full;
                end
                mqbf_pkg::FUNC_POP:
                begin
                    failed_next = empty;
                    do_pop      = cmd.exec && !empty;
                end
                mqbf_pkg::FUNC_QUERY:
                begin
                    failed_next = empty;
                end
                default:
                begin
                    failed_next = 1'b0;
                end
            endcase
        end
    end

    // queue q owns the slice starting at q * DEPTH
    assign base  = AW'(AW'(qi) * AW'(DEPTH));
    assign waddr = base + AW'(wp);
    assign raddr = base + AW'(rp);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.exec)
        begin
            failed_reg <= failed_next;
            pop_ok_reg <= do_pop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUES; i++)
            begin
                write_pos_reg[i] <= '0;
                read_pos_reg[i]  <= '0;
                wrapped_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            if (do_push)
            begin
                if (wp_inc == DEPTH_W)
                begin
                    write_pos_reg[qi] <= '0;
                    wrapped_reg[qi]   <= 1'b1;
                end
                else
                begin
                    write_pos_reg[qi] <= wp_inc[PW-1:0];
                end
            end
            if (do_pop)
            begin
                if (rp_inc == DEPTH_W)
                begin
                    read_pos_reg[qi] <= '0;
                    wrapped_reg[qi]  <= 1'b0;
                end
                else
                begin
                    read_pos_reg[qi] <= rp_inc[PW-1:0];
                end
            end
        end
    end

    // a pop only reads slots written since reset, so the store needs no clearing
    mqbf_ram #(
        .WIDTH(8),
        .WORDS(WORDS)
    ) u_store (
        .clk  (clk),
        .we   (do_push),
        .waddr(waddr),
        .wdata(req_reg.data_in),
        .re   (do_pop),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign rsp.failed   = failed_reg;
    assign rsp.data_out = pop_ok_reg ? rdata : 8'd0;

endmodule

`default_nettype wire

// ----- src/multi_queue_byte_fifo.sv -----
// top level of the multi-queue byte fifo bank
//
//  channel  dir  handshake            beat
//  req      in   req_valid/req_stall  func, queue_id, data_in
//  rsp      out  rsp_valid/rsp_stall  failed, data_out
//
// each request steps through accept, one access to the shared byte store ram
// (its read data is registered), and response, which waits out any rsp stall.
// one request is in flight at a time; req_stall stays high until the
// response beat is taken. reset clears all queue pointers and wrap flags at once.
`default_nettype none

module multi_queue_byte_fifo #(
    parameter int QUEUES = mqbf_pkg::QUEUES_DEFAULT,
    parameter int DEPTH  = mqbf_pkg::DEPTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output      logic           req_stall,
    input  wire mqbf_pkg::req_t req,
    output      logic           rsp_valid,
    input  wire logic           rsp_stall,
    output      mqbf_pkg::rsp_t rsp
);

    mqbf_pkg::cmd_t cmd;

    mqbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .cmd      (cmd)
    );

    mqbf_dp #(
        .QUEUES(QUEUES),
        .DEPTH (DEPTH)
    ) u_dp (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .req  (req),
        .rsp  (rsp)
    );

`ifndef SYNTHESIS
    // the response follows the request beat once the execute state has passed
    a_rsp_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |-> ##2 rsp_valid)
        else $error("response not presented two cycles after request");

    // no new request while a response is pending
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> req_stall)
        else $error("request accepted while response pending");

    // a failed operation never returns data
    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.failed) |-> (rsp.data_out == 8'd0))
        else $error("failed response carries data");
`endif

endmodule

`default_nettype wire
